/* hdl/lfr_pkg.sv */
// Shared types and constants for the LED fade ramp controller.
`timescale 1ns / 1ps

package lfr_pkg;

    localparam int TIME_BITS = 32;
    localparam int INTERVAL_BITS = 32;
    localparam int CMP_W = (TIME_BITS > INTERVAL_BITS) ? TIME_BITS : INTERVAL_BITS;
    localparam int DIV_STEPS = INTERVAL_BITS;
    localparam int CNT_W = $clog2(DIV_STEPS);

    localparam logic [INTERVAL_BITS-1:0] US_PER_MS = 1000;

    localparam logic [2:0] FUNC_TICK     = 3'd0;
    localparam logic [2:0] FUNC_ONCE     = 3'd1;
    localparam logic [2:0] FUNC_REPEAT   = 3'd2;
    localparam logic [2:0] FUNC_CONT     = 3'd3;
    localparam logic [2:0] FUNC_STOP     = 3'd4;
    localparam logic [2:0] FUNC_TO_LEVEL = 3'd5;

    localparam logic [1:0] DIR_OFF  = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    localparam logic [1:0] FADE_OFF = 2'd0;
    localparam logic [1:0] FADE_UP  = 2'd1;
    localparam logic [1:0] FADE_DN  = 2'd2;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  low_level;
        logic [7:0]  high_level;
        logic [1:0]  direction;
        logic [14:0] repeats;
        logic [22:0] time_ms;
        logic [7:0]  end_level;
    } lfr_in_t;

    typedef struct packed {
        logic [7:0]  brightness;
        logic [1:0]  fade_state;
        logic [15:0] pulses_left;
        logic        stepped;
    } lfr_out_t;

endpackage

/* hdl/led_fade_ramp_controller_core.sv */
// LED fade ramp controller: tick and command sequencer with a serial interval divider.
//
//  channel | ports                       | moves
//  --------+-----------------------------+-----------------------------------
//  input   | s_valid s_ready s_data      | one tick or command item
//  result  | m_valid m_ready m_data      | one status item per input item
//
// A tick, a stop or an unused code passes through the accept step and one update step;
// the result register is loaded in the update step. A ramp command passes through
// accept, one multiply, 32 steps of the restoring divider (one quotient bit a cycle),
// and one update step, which loads the result register.
// Reset clears the fade state, timer and bounds; there is no clearing pass.
// s_ready is high only while the sequencer is idle; a waiting result holds the
// update step until the result register frees up.
`timescale 1ns / 1ps

module led_fade_ramp_controller_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lfr_pkg::lfr_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output lfr_pkg::lfr_out_t m_data
);

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_MUL,
        SEQ_DIV,
        SEQ_WRITE
    } seq_t;

    seq_t seq_reg, seq_next;

    lfr_pkg::lfr_in_t  item_reg;
    lfr_pkg::lfr_out_t out_reg, out_next;
    logic              m_valid_reg, m_valid_next;

    logic [lfr_pkg::INTERVAL_BITS-1:0] dvd_reg, dvd_next;
    logic [7:0]                        rem_reg, rem_next;
    logic [7:0]                        div_reg, div_next;
    logic [lfr_pkg::CNT_W-1:0]         cnt_reg, cnt_next;

    logic [7:0]                        level_reg, level_next;
    logic [1:0]                        ramp_reg, ramp_next;
    logic [15:0]                       phases_reg, phases_next;
    logic [7:0]                        lower_reg, lower_next;
    logic [7:0]                        upper_reg, upper_next;
    logic [lfr_pkg::INTERVAL_BITS-1:0] interval_reg, interval_next;
    logic [lfr_pkg::TIME_BITS-1:0]     time_reg, time_next;
    logic [lfr_pkg::TIME_BITS-1:0]     last_reg, last_next;

    logic                              accept;
    logic                              out_free;
    logic                              needs_div;
    logic [7:0]                        op_a;
    logic [7:0]                        op_b;
    logic [7:0]                        range;
    logic [8:0]                        rem_trial;
    logic                              rem_ge;
    logic [lfr_pkg::TIME_BITS-1:0]     time_inc;
    logic [lfr_pkg::TIME_BITS-1:0]     elapsed;
    logic                              due;
    logic [7:0]                        level_step;
    logic                              stepped;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (seq_reg == SEQ_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;

    assign needs_div = (s_data.func == lfr_pkg::FUNC_ONCE)
                    || (s_data.func == lfr_pkg::FUNC_REPEAT)
                    || (s_data.func == lfr_pkg::FUNC_CONT)
                    || (s_data.func == lfr_pkg::FUNC_TO_LEVEL);

    assign op_a  = (item_reg.func == lfr_pkg::FUNC_TO_LEVEL) ? level_reg : item_reg.low_level;
    assign op_b  = (item_reg.func == lfr_pkg::FUNC_TO_LEVEL) ? item_reg.end_level
                                                            : item_reg.high_level;
    assign range = (op_a > op_b) ? (op_a - op_b) : (op_b - op_a);

    assign rem_trial = {rem_reg, dvd_reg[lfr_pkg::INTERVAL_BITS-1]};
    assign rem_ge    = (rem_trial >= {1'b0, div_reg});

    assign time_inc = time_reg + lfr_pkg::TIME_BITS'(1);
    assign elapsed  = time_inc - last_reg;
    assign due      = (lfr_pkg::CMP_W'(elapsed) >= lfr_pkg::CMP_W'(interval_reg));

    always_comb begin
        seq_next     = seq_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        div_next     = div_reg;
        cnt_next     = cnt_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (seq_reg)
            SEQ_IDLE: begin
                if (accept) begin
                    seq_next = needs_div ? SEQ_MUL : SEQ_WRITE;
                end
            end
            SEQ_MUL: begin
                dvd_next = {9'd0, item_reg.time_ms} * lfr_pkg::US_PER_MS;
                rem_next = 8'd0;
                div_next = (range == 8'd0) ? 8'd1 : range;
                cnt_next = '0;
                seq_next = SEQ_DIV;
            end
            SEQ_DIV: begin
                rem_next = rem_ge ? 8'(rem_trial - {1'b0, div_reg}) : rem_trial[7:0];
                dvd_next = {dvd_reg[lfr_pkg::INTERVAL_BITS-2:0], rem_ge};
                cnt_next = cnt_reg + lfr_pkg::CNT_W'(1);
                if (cnt_reg == lfr_pkg::CNT_W'(lfr_pkg::DIV_STEPS - 1)) begin
                    seq_next = SEQ_WRITE;
                end
            end
            SEQ_WRITE: begin
                if (out_free) begin
                    out_next.brightness  = level_next;
                    out_next.fade_state  = ramp_next;
                    out_next.pulses_left = phases_next;
                    out_next.stepped     = stepped;
                    m_valid_next         = 1'b1;
                    seq_next             = SEQ_IDLE;
                end
            end
            default: seq_next = SEQ_IDLE;
        endcase
    end

    always_comb begin
        level_next    = level_reg;
        ramp_next     = ramp_reg;
        phases_next   = phases_reg;
        lower_next    = lower_reg;
        upper_next    = upper_reg;
        interval_next = interval_reg;
        time_next     = time_reg;
        last_next     = last_reg;
        stepped       = 1'b0;
        level_step    = level_reg;
        unique case (item_reg.func)
            lfr_pkg::FUNC_TICK: begin
                time_next = time_inc;
                if ((phases_reg != 16'd0 || ramp_reg != lfr_pkg::FADE_OFF) && due) begin
                    if (ramp_reg == lfr_pkg::FADE_UP) begin
                        level_step = level_reg + 8'd1;
                        stepped    = 1'b1;
                        if (level_step >= upper_reg) begin
                            ramp_next = lfr_pkg::FADE_DN;
                        end
                    end else if (ramp_reg == lfr_pkg::FADE_DN) begin
                        level_step = level_reg - 8'd1;
                        stepped    = 1'b1;
                        if (level_step <= lower_reg) begin
                            ramp_next = lfr_pkg::FADE_UP;
                        end
                    end
                    level_next = level_step;
                    if (ramp_next != ramp_reg && phases_reg != 16'd0) begin
                        phases_next = phases_reg - 16'd1;
                        if (phases_reg == 16'd1) begin
                            ramp_next = lfr_pkg::FADE_OFF;
                        end
                    end
                    last_next = time_inc;
                end
            end
            lfr_pkg::FUNC_ONCE: begin
                if (item_reg.direction == lfr_pkg::DIR_OFF
                        || item_reg.direction == lfr_pkg::DIR_UP) begin
                    ramp_next  = lfr_pkg::FADE_UP;
                    level_next = item_reg.low_level;
                end else if (item_reg.direction == lfr_pkg::DIR_DOWN) begin
                    ramp_next  = lfr_pkg::FADE_DN;
                    level_next = item_reg.high_level;
                end
                lower_next    = item_reg.low_level;
                upper_next    = item_reg.high_level;
                interval_next = dvd_reg;
                phases_next   = 16'd1;
            end
            lfr_pkg::FUNC_REPEAT: begin
                lower_next    = item_reg.low_level;
                upper_next    = item_reg.high_level;
                interval_next = dvd_reg;
                phases_next   = {item_reg.repeats, 1'b0};
                if (ramp_reg == lfr_pkg::FADE_OFF) begin
                    ramp_next = lfr_pkg::FADE_UP;
                end
            end
            lfr_pkg::FUNC_CONT: begin
                lower_next    = item_reg.low_level;
                upper_next    = item_reg.high_level;
                interval_next = dvd_reg;
                if (ramp_reg == lfr_pkg::FADE_OFF) begin
                    ramp_next = lfr_pkg::FADE_UP;
                end
            end
            lfr_pkg::FUNC_STOP: begin
                ramp_next   = lfr_pkg::FADE_OFF;
                phases_next = 16'd0;
            end
            lfr_pkg::FUNC_TO_LEVEL: begin
                lower_next    = level_reg;
                upper_next    = item_reg.end_level;
                interval_next = dvd_reg;
                phases_next   = 16'd1;
                if (level_reg > item_reg.end_level) begin
                    ramp_next  = lfr_pkg::FADE_DN;
                    lower_next = item_reg.end_level;
                end else if (level_reg < item_reg.end_level) begin
                    ramp_next = lfr_pkg::FADE_UP;
                end else begin
                    ramp_next = lfr_pkg::FADE_OFF;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg      <= SEQ_IDLE;
            m_valid_reg  <= 1'b0;
            level_reg    <= '0;
            ramp_reg     <= lfr_pkg::FADE_OFF;
            phases_reg   <= '0;
            lower_reg    <= '0;
            upper_reg    <= '0;
            interval_reg <= '0;
            time_reg     <= '0;
            last_reg     <= '0;
        end else begin
            seq_reg     <= seq_next;
            m_valid_reg <= m_valid_next;
            out_reg     <= out_next;
            if (seq_reg == SEQ_WRITE && out_free) begin
                level_reg    <= level_next;
                ramp_reg     <= ramp_next;
                phases_reg   <= phases_next;
                lower_reg    <= lower_next;
                upper_reg    <= upper_next;
                interval_reg <= interval_next;
                time_reg     <= time_next;
                last_reg     <= last_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        cnt_reg <= cnt_next;
    end

endmodule
